>>> hw/rtl/annexb_nal_unit_classifier_macros.svh
// Assertion macros for the Annex B NAL unit classifier.
// Used by the top level; no other dependencies.
`ifndef ANNEXB_NAL_UNIT_CLASSIFIER_MACROS_SVH
`define ANNEXB_NAL_UNIT_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
`define NALC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("nalc assertion failed");
`define NALC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("nalc assertion failed");
`else
`define NALC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NALC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/nalc_pkg.sv
// Shared types, codes and start-code helpers for the NAL unit classifier.
// No dependencies.
`default_nettype none
package nalc_pkg;

	localparam int VIEW_LEN = 5;

	typedef logic [VIEW_LEN-1:0][7:0] nalc_view_t;

	localparam logic [2:0] CL_NONE  = 3'd0;
	localparam logic [2:0] CL_THREE = 3'd3;
	localparam logic [2:0] CL_FOUR  = 3'd4;

	localparam logic [2:0] KIND_OUTSIDE = 3'd0;
	localparam logic [2:0] KIND_OTHER   = 3'd1;
	localparam logic [2:0] KIND_VPS     = 3'd2;
	localparam logic [2:0] KIND_SPS     = 3'd3;
	localparam logic [2:0] KIND_PPS     = 3'd4;
	localparam logic [2:0] KIND_KEY     = 3'd5;

	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	localparam logic [4:0] H264_IDR = 5'd5;
	localparam logic [4:0] H264_SPS = 5'd7;
	localparam logic [4:0] H264_PPS = 5'd8;

	localparam logic [5:0] H265_VPS      = 6'd32;
	localparam logic [5:0] H265_PPS      = 6'd34;
	localparam logic [5:0] H265_KEY_LO   = 6'd19;
	localparam logic [5:0] H265_KEY_HI   = 6'd21;
	localparam logic [5:0] H265_SET_BASE = 6'd30;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] cl;
		logic       longer;
		logic       last;
	} nalc_entry_t;

	function automatic logic [7:0] nalc_view_at(input nalc_view_t v, input int k);
		logic [7:0] b;
		b = 8'h00;
		if (k >= 0 && k < VIEW_LEN) begin
			b = v[3'(k)];
		end
		return b;
	endfunction

	function automatic logic [2:0] nalc_code_len(input nalc_view_t v, input logic [2:0] n,
		input int i, input logic more);
		int nn;
		logic [2:0] r;
		nn = int'(n);
		r = CL_NONE;
		if ((i + 2 < nn) && nalc_view_at(v, i) == 8'h00 && nalc_view_at(v, i + 1) == 8'h00 &&
			nalc_view_at(v, i + 2) == 8'h01 && ((i + 3 < nn) || more)) begin
			r = CL_THREE;
		end else if ((i + 3 < nn) && nalc_view_at(v, i) == 8'h00 &&
			nalc_view_at(v, i + 1) == 8'h00 && nalc_view_at(v, i + 2) == 8'h00 &&
			nalc_view_at(v, i + 3) == 8'h01 && ((i + 4 < nn) || more)) begin
			r = CL_FOUR;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/nalc_front.sv
// Front end: four-byte lookahead window, start-code detection and final flush.
// Depends on nalc_pkg; feeds nalc_queue.
`default_nettype none
module nalc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	input  wire logic                 q_full,
	output logic                      push,
	output nalc_pkg::nalc_entry_t     push_entry
);
	import nalc_pkg::*;

	logic [3:0][7:0] win_q;
	logic [2:0]      cnt_q;
	logic            fl_busy_q;
	nalc_view_t      fl_v_q;
	logic [4:0][2:0] fl_cl_q;
	logic [4:0]      fl_lg_q;
	logic [2:0]      fl_n_q;
	logic [2:0]      fl_i_q;

	nalc_view_t      view;
	logic [2:0]      n;
	logic            accept;
	logic            fl_last;
	logic [4:0][2:0] cl_fl;
	logic [4:0]      lg_fl;

	assign in_stall = fl_busy_q || q_full;
	assign accept   = in_valid && !in_stall;
	assign n        = cnt_q + 3'd1;
	assign fl_last  = (fl_i_q == fl_n_q - 3'd1);

	always_comb begin
		view = '0;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < cnt_q) begin
				view[k] = win_q[k];
			end
		end
		view[cnt_q] = data_byte;
	end

	always_comb begin
		for (int k = 0; k < VIEW_LEN; k++) begin
			cl_fl[k] = nalc_code_len(view, n, k, 1'b0);
			lg_fl[k] = (k + 1 < int'(n)) &&
				(nalc_code_len(view, n, k + 1, 1'b0) == CL_NONE);
		end
	end

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (fl_busy_q) begin
			push              = !q_full;
			push_entry.data   = fl_v_q[fl_i_q];
			push_entry.cl     = fl_cl_q[fl_i_q];
			push_entry.longer = fl_lg_q[fl_i_q];
			push_entry.last   = fl_last;
		end else if (accept && !last_byte && cnt_q == 3'd4) begin
			push              = 1'b1;
			push_entry.data   = view[0];
			push_entry.cl     = nalc_code_len(view, 3'd5, 0, 1'b1);
			push_entry.longer = (nalc_code_len(view, 3'd5, 1, 1'b1) == CL_NONE);
			push_entry.last   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			cnt_q     <= '0;
			fl_busy_q <= 1'b0;
			fl_v_q    <= '0;
			fl_cl_q   <= '0;
			fl_lg_q   <= '0;
			fl_n_q    <= '0;
			fl_i_q    <= '0;
		end else begin
			if (accept) begin
				if (last_byte) begin
					fl_v_q    <= view;
					fl_cl_q   <= cl_fl;
					fl_lg_q   <= lg_fl;
					fl_n_q    <= n;
					fl_i_q    <= '0;
					fl_busy_q <= 1'b1;
					cnt_q     <= '0;
				end else if (cnt_q == 3'd4) begin
					win_q <= view[4:1];
				end else begin
					win_q[cnt_q[1:0]] <= data_byte;
					cnt_q             <= n;
				end
			end
			if (fl_busy_q && !q_full) begin
				fl_i_q <= fl_i_q + 3'd1;
				if (fl_last) begin
					fl_busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/nalc_queue.sv
// Short register queue between the front end and the back end.
// Depends on nalc_pkg for the entry type.
`default_nettype none
module nalc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire nalc_pkg::nalc_entry_t push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       head_valid,
	output nalc_pkg::nalc_entry_t      head
);
	import nalc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nalc_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/nalc_back.sv
// Back end: NAL header decode, unit tagging, summary flags and output register.
// Depends on nalc_pkg; reads entries from nalc_queue.
`default_nettype none
module nalc_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  codec_mode,
	input  wire logic                  head_valid,
	input  wire nalc_pkg::nalc_entry_t head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic [2:0]                 payload_kind,
	output logic                       nal_first,
	output logic [5:0]                 nal_type,
	output logic                       sets_complete,
	output logic                       key_found,
	output logic                       last_result
);
	import nalc_pkg::*;

	logic [2:0] skip_q;
	logic       pend_q;
	logic [2:0] kind_q;
	logic [5:0] type_q;
	logic [3:0] seen_q;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [2:0] okind_q;
	logic       first_q;
	logic [5:0] otype_q;
	logic       sets_q;
	logic       key_q;
	logic       olast_q;

	logic [2:0] skip_d;
	logic       pend_d;
	logic [2:0] kind_d;
	logic [5:0] type_d;
	logic [3:0] seen_d;
	logic [2:0] o_kind;
	logic [5:0] o_type;
	logic       o_first;
	logic [2:0] dec_kind;
	logic [5:0] dec_type;
	logic       sets;
	logic       key;

	assign pop           = head_valid && (!out_valid_q || !out_stall);
	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign payload_kind  = okind_q;
	assign nal_first     = first_q;
	assign nal_type      = otype_q;
	assign sets_complete = sets_q;
	assign key_found     = key_q;
	assign last_result   = olast_q;

	always_comb begin
		skip_d   = skip_q;
		pend_d   = pend_q;
		kind_d   = kind_q;
		type_d   = type_q;
		seen_d   = seen_q;
		o_kind   = KIND_OUTSIDE;
		o_type   = '0;
		o_first  = 1'b0;
		dec_kind = KIND_OTHER;
		dec_type = '0;
		if (skip_q != 3'd0) begin
			skip_d = skip_q - 3'd1;
		end else if (head.cl != CL_NONE) begin
			skip_d = head.cl - 3'd1;
			kind_d = KIND_OUTSIDE;
			type_d = '0;
			pend_d = 1'b1;
		end else if (pend_q) begin
			pend_d  = 1'b0;
			o_first = 1'b1;
			if (codec_mode == CODEC_H264) begin
				dec_type = {1'b0, head.data[4:0]};
				case (head.data[4:0])
					H264_SPS: dec_kind = KIND_SPS;
					H264_PPS: dec_kind = KIND_PPS;
					H264_IDR: dec_kind = KIND_KEY;
					default:  dec_kind = KIND_OTHER;
				endcase
			end else begin
				dec_type = head.data[6:1];
				if (dec_type >= H265_VPS && dec_type <= H265_PPS) begin
					dec_kind = head.longer ? 3'(dec_type - H265_SET_BASE) : KIND_OTHER;
				end else if (dec_type >= H265_KEY_LO && dec_type <= H265_KEY_HI) begin
					dec_kind = KIND_KEY;
				end
			end
			o_kind = dec_kind;
			o_type = dec_type;
			kind_d = dec_kind;
			type_d = dec_type;
			if (dec_kind >= KIND_VPS) begin
				seen_d = seen_q | (4'b0001 << (dec_kind - KIND_VPS));
			end
		end else begin
			o_kind = kind_q;
			o_type = type_q;
		end
		sets = seen_d[1] && seen_d[2] && (codec_mode == CODEC_H264 || seen_d[0]);
		key  = seen_d[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q      <= '0;
			pend_q      <= 1'b0;
			kind_q      <= KIND_OUTSIDE;
			type_q      <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			okind_q     <= KIND_OUTSIDE;
			first_q     <= 1'b0;
			otype_q     <= '0;
			sets_q      <= 1'b0;
			key_q       <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= head_valid;
			end
			if (pop) begin
				byte_q  <= head.data;
				okind_q <= o_kind;
				first_q <= o_first;
				otype_q <= o_type;
				sets_q  <= head.last && sets;
				key_q   <= head.last && key;
				olast_q <= head.last;
				if (head.last) begin
					skip_q <= '0;
					pend_q <= 1'b0;
					kind_q <= KIND_OUTSIDE;
					type_q <= '0;
					seen_q <= '0;
				end else begin
					skip_q <= skip_d;
					pend_q <= pend_d;
					kind_q <= kind_d;
					type_q <= type_d;
					seen_q <= seen_d;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/annexb_nal_unit_classifier.sv
// Top level of the Annex B NAL unit classifier: config register and wiring.
// Depends on nalc_pkg, nalc_front, nalc_queue, nalc_back and the macros header.
`default_nettype none
`include "annexb_nal_unit_classifier_macros.svh"
// Takes one stream byte per cycle while not stalled and returns every byte in order,
// tagged with the kind and type of its NAL unit, four bytes behind the input while the
// lookahead window fills. Bytes stream back to back at one per cycle unless stalled. A
// beat marked last_byte flushes the window: the input stalls while the flush pushes the
// held bytes and the last byte (up to five) into the queue one per cycle, pausing on a
// full queue. A queue of QUEUE_DEPTH entries decouples start-code detection from header
// decoding and the output register, so an output stall reaches the input only once the
// queue fills. The final result carries sets_complete and key_found. The user must
// write codec_mode via the cfg channel between buffers; the block does not enforce it.
module annexb_nal_unit_classifier #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       codec_mode,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [2:0]      payload_kind,
	output logic            nal_first,
	output logic [5:0]      nal_type,
	output logic            sets_complete,
	output logic            key_found,
	output logic            last_result
);
	import nalc_pkg::*;

	logic        codec_mode_q;
	logic        q_full;
	logic        push;
	nalc_entry_t push_entry;
	logic        pop;
	logic        head_valid;
	nalc_entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= CODEC_H264;
		end else if (cfg_valid && cfg_ready) begin
			codec_mode_q <= codec_mode;
		end
	end

	nalc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	nalc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nalc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.codec_mode    (codec_mode_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.payload_kind  (payload_kind),
		.nal_first     (nal_first),
		.nal_type      (nal_type),
		.sets_complete (sets_complete),
		.key_found     (key_found),
		.last_result   (last_result)
	);

	`NALC_ASSERT_IMP(a_outside_no_type, clk, arst_n, out_valid && payload_kind == KIND_OUTSIDE, nal_type == 6'd0 && !nal_first)
	`NALC_ASSERT_IMP(a_summary_on_last, clk, arst_n, out_valid && !last_result, !sets_complete && !key_found)
	`NALC_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, payload_kind <= KIND_KEY)
	`NALC_ASSERT_NXT(a_flush_stalls, clk, arst_n, in_valid && !in_stall && last_byte, in_stall)

endmodule
`default_nettype wire
